/* hw/rtl/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// Base64 decoder package
// Shared types, constants and the character classifier.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // Default depth of the group queue between front and back
  localparam int unsigned QDepthDefault = 4;

  // Group of decoded bytes handed from front to back
  typedef struct packed {
    logic [23:0] word;    // first byte in bits 23:16
    logic [1:0]  nbytes;  // 0..3 bytes carried
    logic        eom;     // group closes the message
  } grp_t;

  // Character classification result
  typedef struct packed {
    logic       valid;    // character is in the alphabet
    logic [5:0] sextet;
  } sextet_t;

  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7A;
  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChDigit9 = 8'h39;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChSlash  = 8'h2F;

  // Map a character code to its sextet value
  function automatic sextet_t classify(input logic [7:0] c);
    sextet_t    r;
    logic [7:0] d;
    r = '0;
    d = '0;
    if (c >= ChUpperA && c <= ChUpperZ) begin
      d = c - ChUpperA;
      r = '{valid: 1'b1, sextet: d[5:0]};
    end else if (c >= ChLowerA && c <= ChLowerZ) begin
      d = c - ChLowerA + 8'd26;
      r = '{valid: 1'b1, sextet: d[5:0]};
    end else if (c >= ChDigit0 && c <= ChDigit9) begin
      d = c - ChDigit0 + 8'd52;
      r = '{valid: 1'b1, sextet: d[5:0]};
    end else if (c == ChPlus) begin
      r = '{valid: 1'b1, sextet: 6'd62};
    end else if (c == ChSlash) begin
      r = '{valid: 1'b1, sextet: 6'd63};
    end
    return r;
  endfunction

endpackage

/* hw/rtl/b64d_front.sv */
// ----------------------------------------------------------------------------
// Base64 decoder front end
// Classifies each character, gathers sextets and emits byte groups.
// ----------------------------------------------------------------------------
module b64d_front
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  input  logic       end_of_text,
  output logic       grp_valid,
  input  logic       grp_ready,
  output grp_t       grp
);

  logic [17:0] held_r, held_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        halted_r, halted_nxt;

  sextet_t     cls;
  logic [17:0] held_upd;
  logic [1:0]  cnt_upd;
  logic        halted_upd;
  logic        accept;

  // Stall the character stream whenever the queue cannot take a group
  assign in_ready = grp_ready;
  assign accept   = in_valid && grp_ready;
  assign cls      = classify(char_code);

  // Gather the sextet, build the group and flush at end of message
  always_comb begin
    held_upd   = held_r;
    cnt_upd    = cnt_r;
    halted_upd = halted_r;
    grp        = '0;
    if (!halted_r) begin
      if (!cls.valid) begin
        halted_upd = 1'b1;
      end else if (cnt_r == 2'd3) begin
        grp.word   = {held_r, cls.sextet};
        grp.nbytes = 2'd3;
        held_upd   = '0;
        cnt_upd    = '0;
      end else begin
        held_upd = {held_r[11:0], cls.sextet};
        cnt_upd  = cnt_r + 2'd1;
      end
    end
    if (end_of_text) begin
      grp.eom = 1'b1;
      if (cnt_upd == 2'd2) begin
        grp.word   = {held_upd[11:0], 12'd0};
        grp.nbytes = 2'd1;
      end else if (cnt_upd == 2'd3) begin
        grp.word   = {held_upd, 6'd0};
        grp.nbytes = 2'd2;
      end
      held_upd   = '0;
      cnt_upd    = '0;
      halted_upd = 1'b0;
    end
    grp_valid = in_valid && ((grp.nbytes != 2'd0) || end_of_text);
  end

  // Advance state only on an accepted transaction
  always_comb begin
    held_nxt   = accept ? held_upd   : held_r;
    cnt_nxt    = accept ? cnt_upd    : cnt_r;
    halted_nxt = accept ? halted_upd : halted_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= '0;
      cnt_r    <= '0;
      halted_r <= 1'b0;
    end else begin
      held_r   <= held_nxt;
      cnt_r    <= cnt_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

/* hw/rtl/b64d_queue.sv */
// ----------------------------------------------------------------------------
// Base64 decoder group queue
// Small FIFO of byte groups between front end and back end.
// ----------------------------------------------------------------------------
module b64d_queue
  import b64d_pkg::*;
#(
  parameter int unsigned QDepth = QDepthDefault
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  grp_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output grp_t pop_data
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QDepth);

  grp_t            mem_r [QDepth];
  logic [PtrW-1:0] wr_r, wr_nxt;
  logic [PtrW-1:0] rd_r, rd_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign push_ready = (cnt_r != CntFull);
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PtrLast) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PtrLast) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store the group
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

/* hw/rtl/b64d_back.sv */
// ----------------------------------------------------------------------------
// Base64 decoder back end
// Splits each byte group into single-byte output transactions.
// ----------------------------------------------------------------------------
module b64d_back
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       grp_valid,
  output logic       grp_ready,
  input  grp_t       grp,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       end_of_message
);

  logic [1:0] idx_r, idx_nxt;
  logic       vld_r, vld_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       has_r, has_nxt;
  logic       eom_r, eom_nxt;
  logic       load, last_of_grp;
  logic [7:0] sel_byte;

  // Pick the current byte of the group
  always_comb begin
    unique case (idx_r)
      2'd0:    sel_byte = grp.word[23:16];
      2'd1:    sel_byte = grp.word[15:8];
      default: sel_byte = grp.word[7:0];
    endcase
  end

  assign load        = grp_valid && (!vld_r || out_ready);
  assign last_of_grp = (grp.nbytes == 2'd0) || (idx_r == grp.nbytes - 2'd1);
  assign grp_ready   = load && last_of_grp;

  // Fill the output register, hold it while stalled
  always_comb begin
    idx_nxt  = idx_r;
    vld_nxt  = vld_r;
    byte_nxt = byte_r;
    has_nxt  = has_r;
    eom_nxt  = eom_r;
    if (load) begin
      vld_nxt  = 1'b1;
      byte_nxt = (grp.nbytes == 2'd0) ? 8'd0 : sel_byte;
      has_nxt  = (grp.nbytes != 2'd0);
      eom_nxt  = grp.eom && last_of_grp;
      idx_nxt  = last_of_grp ? 2'd0 : idx_r + 2'd1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    has_r  <= has_nxt;
    eom_r  <= eom_nxt;
  end

  assign out_valid      = vld_r;
  assign out_byte       = byte_r;
  assign has_byte       = has_r;
  assign end_of_message = eom_r;

endmodule

/* hw/rtl/base64_stream_decoder.sv */
// ----------------------------------------------------------------------------
// Base64 stream decoder
// Decodes base64 text, one character per transaction, into bytes.
// ----------------------------------------------------------------------------
//  channel | direction | tdata          | tuser    | tlast
//  in_     | slave     | char_code[7:0] | -        | end_of_text
//  out_    | master    | out_byte[7:0]  | has_byte | end_of_message
//
// The front end takes one character per cycle and pushes a group of up to
// three bytes into a QDepth-entry queue; the back end sends one byte per cycle
// from a registered output. A full group of four characters thus yields three
// output bytes. Input stalls only when the queue is full; output stalls hold
// the output register. Reset is synchronous and clears the sextet state, queue
// pointers and output valid.
// ----------------------------------------------------------------------------
module base64_stream_decoder
  import b64d_pkg::*;
#(
  parameter int unsigned QDepth = QDepthDefault
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tuser,  // [0] has_byte
  output logic       out_tlast
);

  logic push_valid, push_ready, pop_valid, pop_ready;
  grp_t push_data, pop_data;

  b64d_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .char_code   (in_tdata),
    .end_of_text (in_tlast),
    .grp_valid   (push_valid),
    .grp_ready   (push_ready),
    .grp         (push_data)
  );

  b64d_queue #(
    .QDepth (QDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  b64d_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .grp_valid      (pop_valid),
    .grp_ready      (pop_ready),
    .grp            (pop_data),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_byte       (out_tdata),
    .has_byte       (out_tuser),
    .end_of_message (out_tlast)
  );

endmodule
